### rtl/mclt_pkg.sv
// ----------------------------------------------------------------------------
// Mail command line tokenizer package
// Field widths, character codes, register indexes and the lowercase helper.
// ----------------------------------------------------------------------------
package mclt_pkg;

    // Payload widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned IDX_W   = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [IDX_W-1:0]  cfg_idx_t;

    // Kind of an emitted byte.
    localparam kind_t KIND_NONE = 2'd0;
    localparam kind_t KIND_CMD  = 2'd1;
    localparam kind_t KIND_ARG  = 2'd2;

    // Configuration register indexes.
    localparam cfg_idx_t REG_MAX_CMD_LEN = 2'd0;
    localparam cfg_idx_t REG_MAX_ARG_LEN = 2'd1;
    localparam cfg_idx_t REG_MAX_ARG_CNT = 2'd2;

    // Reset values of the limits.
    localparam byte_t RST_MAX_CMD_LEN = 8'd4;
    localparam byte_t RST_MAX_ARG_LEN = 8'd40;
    localparam slot_t RST_MAX_ARG_CNT = 4'd2;

    // Character codes.
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_UP_A  = 8'h41;
    localparam byte_t CH_UP_Z  = 8'h5A;
    localparam byte_t CASE_OFS = 8'h20;

    // ASCII uppercase letters map to lowercase; all other bytes pass.
    function automatic byte_t to_lower(input byte_t c);
        byte_t r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage

### rtl/mclt_in_if.sv
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel that carries one byte of the command line stream.
// ----------------------------------------------------------------------------
interface mclt_in_if;
    logic            valid;
    logic            ready;
    mclt_pkg::byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/mclt_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one tagged byte and the line status.
// ----------------------------------------------------------------------------
interface mclt_out_if;
    logic            valid;
    logic            ready;
    mclt_pkg::byte_t out_char;
    mclt_pkg::kind_t char_kind;
    mclt_pkg::slot_t arg_slot;
    mclt_pkg::byte_t char_position;
    logic            line_done;
    logic            line_error;
    mclt_pkg::slot_t arg_total;
    mclt_pkg::byte_t command_length;

    modport source (
        output valid, output out_char, output char_kind, output arg_slot,
        output char_position, output line_done, output line_error,
        output arg_total, output command_length, input ready
    );
    modport sink (
        input valid, input out_char, input char_kind, input arg_slot,
        input char_position, input line_done, input line_error,
        input arg_total, input command_length, output ready
    );
endinterface

### rtl/mclt_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface mclt_cfg_if;
    logic               valid;
    logic               ready;
    mclt_pkg::cfg_idx_t index;
    mclt_pkg::byte_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mail_command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Mail command line tokenizer
// Splits a CRLF-ended command line into a command and arguments, one byte
// per request, and emits each kept byte lowercased with its tag.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one byte of the line per request (valid/ready).
//   result : exactly one result per input byte, in order: the tagged byte
//            (kind, argument slot, position) and the line status (done,
//            sticky error, argument count, command length).
//   cfg    : register writes (index 0 command length limit, 1 argument
//            length limit, 2 argument count limit); always ready, and to be
//            written only while no byte is in flight.
// An accepted byte passes through the input register, then through the state
// update into the result register. Throughput is one byte per cycle while
// the receiver takes results, set by the combinational phase and counter
// update between the two registers.
// Reset returns the line state to the start phase with zero counts and a
// clear error, and loads the default limits (4, 40, 2).
// When the receiver stalls, the result register holds its request and the
// input register still takes one more byte; after that, ready drops until
// the result is taken.
// ----------------------------------------------------------------------------
module mail_command_line_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    mclt_in_if.sink    item,
    mclt_out_if.source result,
    mclt_cfg_if.sink   cfg
);

    // Phase codes.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_ARGS  = 3'd2;
    localparam logic [2:0] PH_CR    = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // Configuration registers.
    mclt_pkg::byte_t max_cmd_len_reg;
    mclt_pkg::byte_t max_arg_len_reg;
    mclt_pkg::slot_t max_arg_cnt_reg;

    // Input register.
    logic            in_valid_reg;
    mclt_pkg::byte_t in_byte_reg;

    // Line state.
    logic [2:0]      phase_reg, phase_next;
    mclt_pkg::byte_t cmd_count_reg, cmd_count_next;
    mclt_pkg::slot_t arg_count_reg, arg_count_next;
    mclt_pkg::byte_t arg_bytes_reg, arg_bytes_next;
    logic            error_reg, error_next;

    // Result register.
    logic            out_valid_reg;
    mclt_pkg::byte_t out_char_reg, out_char_next;
    mclt_pkg::kind_t kind_reg, kind_next;
    mclt_pkg::slot_t slot_reg, slot_next;
    mclt_pkg::byte_t pos_reg, pos_next;
    logic            done_reg, done_next;

    logic            advance;
    mclt_pkg::byte_t lower_byte;
    logic            is_space;
    logic            is_cr;

    // The input byte moves on when the result register is free or drains.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cmd_len_reg <= mclt_pkg::RST_MAX_CMD_LEN;
            max_arg_len_reg <= mclt_pkg::RST_MAX_ARG_LEN;
            max_arg_cnt_reg <= mclt_pkg::RST_MAX_ARG_CNT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mclt_pkg::REG_MAX_CMD_LEN: max_cmd_len_reg <= cfg.data;
                mclt_pkg::REG_MAX_ARG_LEN: max_arg_len_reg <= cfg.data;
                mclt_pkg::REG_MAX_ARG_CNT:
                    max_arg_cnt_reg <= cfg.data[mclt_pkg::SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_byte_reg <= item.in_byte;
        end
    end

    assign lower_byte = mclt_pkg::to_lower(in_byte_reg);
    assign is_space   = (in_byte_reg == mclt_pkg::CH_SPACE);
    assign is_cr      = (in_byte_reg == mclt_pkg::CH_CR);

    // Phase and counter update for the byte in the input register.
    always_comb
    begin
        phase_next     = phase_reg;
        cmd_count_next = cmd_count_reg;
        arg_count_next = arg_count_reg;
        arg_bytes_next = arg_bytes_reg;
        error_next     = error_reg;
        out_char_next  = '0;
        kind_next      = mclt_pkg::KIND_NONE;
        slot_next      = '0;
        pos_next       = '0;
        done_next      = 1'b0;

        unique case (phase_reg) inside
            PH_START, PH_CMD:
            begin
                if (phase_reg == PH_CMD && is_space)
                begin
                    phase_next     = PH_ARGS;
                    arg_bytes_next = '0;
                end
                else if (phase_reg == PH_CMD && is_cr)
                begin
                    phase_next = PH_CR;
                end
                else
                begin
                    phase_next = PH_CMD;
                    if (cmd_count_reg >= max_cmd_len_reg)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        out_char_next  = lower_byte;
                        kind_next      = mclt_pkg::KIND_CMD;
                        pos_next       = cmd_count_reg;
                        cmd_count_next = cmd_count_reg + 8'd1;
                    end
                end
            end
            PH_ARGS:
            begin
                if (is_space || is_cr)
                begin
                    // A space or the final CR closes the current argument if a slot is left.
                    if (arg_count_reg >= max_arg_cnt_reg)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        arg_count_next = arg_count_reg + 4'd1;
                        arg_bytes_next = '0;
                    end
                    if (is_cr)
                    begin
                        phase_next = PH_CR;
                    end
                end
                else if (arg_count_reg >= max_arg_cnt_reg ||
                         arg_bytes_reg >= max_arg_len_reg)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    out_char_next  = lower_byte;
                    kind_next      = mclt_pkg::KIND_ARG;
                    slot_next      = arg_count_reg;
                    pos_next       = arg_bytes_reg;
                    arg_bytes_next = arg_bytes_reg + 8'd1;
                end
            end
            PH_CR:
            begin
                if (in_byte_reg == mclt_pkg::CH_LF)
                begin
                    phase_next = PH_DONE;
                    done_next  = 1'b1;
                end
                else
                begin
                    phase_next     = PH_START;
                    cmd_count_next = '0;
                    arg_count_next = '0;
                    arg_bytes_next = '0;
                    error_next     = 1'b0;
                end
            end
            default:
            begin
                // After a completed line, or on an unused code, start over.
                phase_next     = PH_START;
                cmd_count_next = '0;
                arg_count_next = '0;
                arg_bytes_next = '0;
                error_next     = 1'b0;
            end
        endcase
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            cmd_count_reg <= '0;
            arg_count_reg <= '0;
            arg_bytes_reg <= '0;
            error_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            cmd_count_reg <= cmd_count_next;
            arg_count_reg <= arg_count_next;
            arg_bytes_reg <= arg_bytes_next;
            error_reg     <= error_next;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_char_reg <= out_char_next;
            kind_reg     <= kind_next;
            slot_reg     <= slot_next;
            pos_reg      <= pos_next;
            done_reg     <= done_next;
        end
    end

    // The status fields show the line state after the byte in the result.
    assign result.valid          = out_valid_reg;
    assign result.out_char       = out_char_reg;
    assign result.char_kind      = kind_reg;
    assign result.arg_slot       = slot_reg;
    assign result.char_position  = pos_reg;
    assign result.line_done      = done_reg;
    assign result.line_error     = error_reg;
    assign result.arg_total      = arg_count_reg;
    assign result.command_length = cmd_count_reg;

    // A command byte is only ever kept before any argument is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == mclt_pkg::KIND_CMD |-> arg_count_reg == '0)
    else $error("command byte emitted after an argument was closed");

    // The byte that completes a line is never a kept byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> kind_reg == mclt_pkg::KIND_NONE &&
        phase_reg == PH_DONE)
    else $error("line done with a kept byte or wrong phase");

    // A dropped byte carries no character and no position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == mclt_pkg::KIND_NONE |->
        out_char_reg == '0 && pos_reg == '0 && slot_reg == '0)
    else $error("dropped byte carries payload");

    // The line state only moves when a byte passes into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(cmd_count_reg) &&
        $stable(arg_count_reg) && $stable(error_reg))
    else $error("line state changed without a byte");

endmodule

### bench/tb_mail_command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Testbench for the mail command line tokenizer
// Sends command line bytes through the input channel under random source
// gaps and result stalls, predicts every tagged byte and line status in the
// bench, and compares each result field by field in arrival order. Limits
// are rewritten between phases while no request is in flight.
// ----------------------------------------------------------------------------
module tb_mail_command_line_tokenizer;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned PHASE_BYTES  = 175;

    // Line phases of the tokenizer.
    typedef enum logic [2:0] {
        PH_START,
        PH_COMMAND,
        PH_ARGS,
        PH_AFTER_CR,
        PH_LINE_DONE
    } line_phase_t;

    // One result: the tagged byte and the line status after it.
    typedef struct packed {
        mclt_pkg::byte_t out_char;
        mclt_pkg::kind_t char_kind;
        mclt_pkg::slot_t arg_slot;
        mclt_pkg::byte_t char_position;
        logic            line_done;
        logic            line_error;
        mclt_pkg::slot_t arg_total;
        mclt_pkg::byte_t command_length;
    } line_tag_t;

    logic clk;
    logic rst_n;

    mclt_in_if  item ();
    mclt_out_if result ();
    mclt_cfg_if cfg ();

    mail_command_line_tokenizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    // Bench copy of the limits and the line state.
    mclt_pkg::byte_t lim_cmd_len = mclt_pkg::RST_MAX_CMD_LEN;
    mclt_pkg::byte_t lim_arg_len = mclt_pkg::RST_MAX_ARG_LEN;
    mclt_pkg::slot_t lim_arg_cnt = mclt_pkg::RST_MAX_ARG_CNT;
    line_phase_t     line_phase  = PH_START;
    mclt_pkg::byte_t cmd_len     = '0;
    mclt_pkg::slot_t arg_cnt     = '0;
    mclt_pkg::byte_t arg_len     = '0;
    logic            line_err    = 1'b0;

    line_tag_t   expected_tags[$];
    int unsigned fail_count  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_hold     = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("TEST FAILED");
        $finish;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return 0;
        end
        else if (roll < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Clear the line state back to the start phase.
    function automatic void restart_line();
        line_phase = PH_START;
        cmd_len    = '0;
        arg_cnt    = '0;
        arg_len    = '0;
        line_err   = 1'b0;
    endfunction

    // Advance the bench line state by one byte and return its result.
    function automatic line_tag_t tokenize_byte(input mclt_pkg::byte_t c);
        line_tag_t       t;
        mclt_pkg::byte_t low;
        t   = '0;
        low = (c >= mclt_pkg::CH_UP_A && c <= mclt_pkg::CH_UP_Z) ?
              mclt_pkg::byte_t'(c + mclt_pkg::CASE_OFS) : c;
        case (line_phase) inside
            PH_START, PH_COMMAND:
            begin
                if (line_phase == PH_COMMAND && c == mclt_pkg::CH_SPACE)
                begin
                    line_phase = PH_ARGS;
                    arg_len    = '0;
                end
                else if (line_phase == PH_COMMAND && c == mclt_pkg::CH_CR)
                begin
                    line_phase = PH_AFTER_CR;
                end
                else
                begin
                    line_phase = PH_COMMAND;
                    if (cmd_len >= lim_cmd_len)
                    begin
                        line_err = 1'b1;
                    end
                    else
                    begin
                        t.out_char      = low;
                        t.char_kind     = mclt_pkg::KIND_CMD;
                        t.char_position = cmd_len;
                        cmd_len         = cmd_len + 1'b1;
                    end
                end
            end
            PH_ARGS:
            begin
                if (c == mclt_pkg::CH_SPACE || c == mclt_pkg::CH_CR)
                begin
                    // A separator closes the current argument if a slot is left.
                    if (arg_cnt >= lim_arg_cnt)
                    begin
                        line_err = 1'b1;
                    end
                    else
                    begin
                        arg_cnt = arg_cnt + 1'b1;
                        arg_len = '0;
                    end
                    if (c == mclt_pkg::CH_CR)
                    begin
                        line_phase = PH_AFTER_CR;
                    end
                end
                else if (arg_cnt >= lim_arg_cnt || arg_len >= lim_arg_len)
                begin
                    line_err = 1'b1;
                end
                else
                begin
                    t.out_char      = low;
                    t.char_kind     = mclt_pkg::KIND_ARG;
                    t.arg_slot      = arg_cnt;
                    t.char_position = arg_len;
                    arg_len         = arg_len + 1'b1;
                end
            end
            PH_AFTER_CR:
            begin
                if (c == mclt_pkg::CH_LF)
                begin
                    line_phase  = PH_LINE_DONE;
                    t.line_done = 1'b1;
                end
                else
                begin
                    restart_line();
                end
            end
            default:
            begin
                restart_line();
            end
        endcase
        t.line_error     = line_err;
        t.arg_total      = arg_cnt;
        t.command_length = cmd_len;
        return t;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin : check_results
        line_tag_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_tags.size() == 0)
            begin
                $error("result request with no byte outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_tags.pop_front();
                compare_field("out_char", want.out_char, result.out_char);
                compare_field("char_kind", want.char_kind, result.char_kind);
                compare_field("arg_slot", want.arg_slot, result.arg_slot);
                compare_field("char_position", want.char_position,
                              result.char_position);
                compare_field("line_done", want.line_done, result.line_done);
                compare_field("line_error", want.line_error, result.line_error);
                compare_field("arg_total", want.arg_total, result.arg_total);
                compare_field("command_length", want.command_length,
                              result.command_length);
            end
        end
        if (rx_hold != 0)
        begin
            rx_hold--;
            result.ready <= 1'b0;
        end
        else
        begin
            result.ready <= 1'b1;
            rx_hold = rx_steady ? 0 : draw_gap();
        end
    end

    // Send one byte request and record its expected result once accepted.
    task automatic send_byte(input mclt_pkg::byte_t b);
        int unsigned gap;
        gap = tx_steady ? 0 : draw_gap();
        if (gap != 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid   <= 1'b1;
        item.in_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!item.ready);
        expected_tags.push_back(tokenize_byte(b));
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(mclt_pkg::byte_t'(s[i]));
        end
    endtask

    task automatic end_line();
        send_byte(mclt_pkg::CH_CR);
        send_byte(mclt_pkg::CH_LF);
    endtask

    // Stop sending and wait until every result has been taken.
    task automatic wait_idle();
        item.valid <= 1'b0;
        while (expected_tags.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write request; valid stays high for a following write.
    task automatic write_reg(input mclt_pkg::cfg_idx_t idx,
                             input mclt_pkg::byte_t val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        case (idx)
            mclt_pkg::REG_MAX_CMD_LEN: lim_cmd_len = val;
            mclt_pkg::REG_MAX_ARG_LEN: lim_arg_len = val;
            mclt_pkg::REG_MAX_ARG_CNT: lim_arg_cnt = val[mclt_pkg::SLOT_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrite all three limits once the block is idle.
    task automatic write_limits(input mclt_pkg::byte_t cmd_lim,
                                input mclt_pkg::byte_t arg_lim,
                                input mclt_pkg::byte_t cnt_lim);
        wait_idle();
        write_reg(mclt_pkg::REG_MAX_CMD_LEN, cmd_lim);
        write_reg(mclt_pkg::REG_MAX_ARG_LEN, arg_lim);
        write_reg(mclt_pkg::REG_MAX_ARG_CNT, cnt_lim);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reset limits: command overflow, empty argument closed by CR, byte after
    // a completed line, space as first command byte, non-LF after CR.
    task automatic test_default_limits();
        send_text("Quit5 ");
        end_line();
        send_byte(8'hFF);
        send_text(" ");
        send_byte(mclt_pkg::CH_CR);
        send_byte(8'h00);
    endtask

    // Limits of one: command full, argument full, and the count limit on
    // both a second argument close and the final CR.
    task automatic test_tight_limits();
        write_limits(8'd1, 8'd1, 8'd1);
        send_text("ab cd  ");
        end_line();
    endtask

    // Limits dropped to zero in the middle of an argument, then a new line
    // whose first byte hits a zero command limit.
    task automatic test_limit_change_mid_line();
        write_limits(mclt_pkg::RST_MAX_CMD_LEN, mclt_pkg::RST_MAX_ARG_LEN,
                     {4'h0, mclt_pkg::RST_MAX_ARG_CNT});
        send_text("A b");
        write_limits(8'd0, 8'd0, 8'hF0);
        send_text("c ");
        end_line();
        send_byte(8'h80);
        send_text("Y");
        end_line();
    endtask

    // A word byte: mostly printable, sometimes any value.
    function automatic mclt_pkg::byte_t draw_word_byte();
        if ($urandom_range(0, 9) == 0)
        begin
            return mclt_pkg::byte_t'($urandom_range(0, 255));
        end
        return mclt_pkg::byte_t'($urandom_range(8'h21, 8'h7E));
    endfunction

    // Mostly well-formed lines with random content, plus noise and
    // broken endings.
    task automatic send_random_line();
        int unsigned     cmd_n;
        int unsigned     arg_n;
        int unsigned     word_n;
        int unsigned     word_cap;
        int unsigned     roll;
        mclt_pkg::byte_t junk;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(mclt_pkg::byte_t'($urandom_range(0, 255)));
            return;
        end
        cmd_n = $urandom_range(0, (lim_cmd_len > 6 ? 6 : lim_cmd_len) + 1);
        repeat (cmd_n) send_byte(draw_word_byte());
        word_cap = (lim_arg_len > 6) ? 6 : lim_arg_len;
        arg_n    = $urandom_range(0, lim_arg_cnt + 1);
        for (int a = 0; a < arg_n; a++)
        begin
            send_byte(mclt_pkg::CH_SPACE);
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte(mclt_pkg::CH_SPACE);
            end
            word_n = $urandom_range(0, word_cap + 1);
            repeat (word_n) send_byte(draw_word_byte());
        end
        if (arg_n != 0 && $urandom_range(0, 6) == 0)
        begin
            send_byte(mclt_pkg::CH_SPACE);
        end
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            end_line();
        end
        else if (roll < 88)
        begin
            send_byte(mclt_pkg::CH_CR);
            do
            begin
                junk = mclt_pkg::byte_t'($urandom_range(0, 255));
            end
            while (junk == mclt_pkg::CH_LF);
            send_byte(junk);
        end
        else if (roll < 94)
        begin
            send_byte(mclt_pkg::CH_CR);
        end
    endtask

    // Random lines over the reset limits, the extremes and random limits. Each limit
    // change waits for the block to drain, so the sender pauses until every
    // expected result has come.
    task automatic test_random_lines();
        int unsigned target;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_limits(mclt_pkg::RST_MAX_CMD_LEN, mclt_pkg::RST_MAX_ARG_LEN,
                                {4'h0, mclt_pkg::RST_MAX_ARG_CNT});
                1: write_limits(8'd255, 8'd255, 8'd15);
                2: write_limits(8'd1, 8'd1, 8'd1);
                3: write_limits(mclt_pkg::byte_t'($urandom_range(0, 8)),
                                mclt_pkg::byte_t'($urandom_range(0, 8)),
                                mclt_pkg::byte_t'($urandom_range(0, 15)));
                default: write_limits(mclt_pkg::byte_t'($urandom_range(1, 10)),
                                      mclt_pkg::byte_t'($urandom_range(1, 12)),
                                      mclt_pkg::byte_t'($urandom_range(1, 15)));
            endcase
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                tx_steady = ($urandom_range(0, 4) == 0);
                rx_steady = ($urandom_range(0, 4) == 0);
                send_random_line();
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n         <= 1'b0;
        item.valid    <= 1'b0;
        item.in_byte  <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= mclt_pkg::REG_MAX_CMD_LEN;
        cfg.data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limits();
        test_tight_limits();
        test_limit_change_mid_line();
        test_random_lines();

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_idle();
        if (fail_count == 0 && expected_tags.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/mclt_pkg.sv
rtl/mclt_in_if.sv
rtl/mclt_out_if.sv
rtl/mclt_cfg_if.sv
rtl/mail_command_line_tokenizer.sv
bench/tb_mail_command_line_tokenizer.sv
